>>> hw/rtl/aabb_frustum_classify_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for aabb_frustum_classify_top
// Immediate-implication and next-cycle forms, clocked on aclk, off in reset.
// ----------------------------------------------------------------------------
`ifndef AABB_FRUSTUM_CLASSIFY_TOP_ASSERT_SVH
`define AABB_FRUSTUM_CLASSIFY_TOP_ASSERT_SVH

`define AFC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`define AFC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/aabb_fc_pkg.sv
// ----------------------------------------------------------------------------
// aabb_fc_pkg
// Shared constants and types for the box/frustum classifier.
// ----------------------------------------------------------------------------
package aabb_fc_pkg;

    localparam int PLANE_COUNT_DEF = 6;
    localparam int COORD_BITS_DEF  = 16;

    localparam int REG_COUNT       = 6;
    localparam int CFG_INDEX_BITS  = 3;
    localparam int PLANE_BITS      = 64;
    localparam int NORMAL_BITS     = 16;
    localparam int D_SHIFT         = 15;
    localparam int TAG_BITS        = 16;
    localparam int CLASS_BITS      = 2;
    localparam int AXES            = 3;

    typedef enum logic [CLASS_BITS-1:0] {
        CLASS_OUTSIDE  = 2'd0,
        CLASS_INSIDE   = 2'd1,
        CLASS_STRADDLE = 2'd2
    } cull_class_t;

    typedef struct packed {
        logic below_outer;
        logic below_inner;
    } plane_flags_t;

endpackage

>>> hw/rtl/aabb_fc_plane_test.sv
// ----------------------------------------------------------------------------
// aabb_fc_plane_test
// Tests a doubled centre/extent box against one packed plane word.
// ----------------------------------------------------------------------------
module aabb_fc_plane_test #(
    parameter int COORD_BITS = aabb_fc_pkg::COORD_BITS_DEF
) (
    input  logic [aabb_fc_pkg::PLANE_BITS-1:0] plane_word,
    input  logic signed [COORD_BITS:0]          c2 [aabb_fc_pkg::AXES],
    input  logic signed [COORD_BITS:0]          e2 [aabb_fc_pkg::AXES],
    output aabb_fc_pkg::plane_flags_t            flags
);

    localparam int NB     = aabb_fc_pkg::NORMAL_BITS;
    localparam int EXT_W  = COORD_BITS + 1;
    localparam int PROD_W = NB + 1 + EXT_W;
    localparam int SUM_W  = (COORD_BITS + 18 > 30) ? COORD_BITS + 20 : 32;

    logic signed [NB-1:0]     n     [aabb_fc_pkg::AXES];
    logic signed [NB:0]       n_mag [aabb_fc_pkg::AXES];
    logic signed [PROD_W-1:0] dist_prod [aabb_fc_pkg::AXES];
    logic signed [PROD_W-1:0] rad_prod  [aabb_fc_pkg::AXES];
    logic signed [NB-1:0]     d;
    logic signed [SUM_W-1:0]  d_term;
    logic signed [SUM_W-1:0]  plane_dist;
    logic signed [SUM_W-1:0]  rad;
    logic signed [SUM_W-1:0]  outer;
    logic signed [SUM_W-1:0]  inner;

    always_comb begin
        d      = plane_word[aabb_fc_pkg::AXES*NB +: NB];
        d_term = {{(SUM_W-NB-aabb_fc_pkg::D_SHIFT){d[NB-1]}}, d,
                  {aabb_fc_pkg::D_SHIFT{1'b0}}};
        plane_dist = d_term;
        rad        = '0;
        for (int a = 0; a < aabb_fc_pkg::AXES; a++) begin
            n[a]     = plane_word[NB*a +: NB];
            n_mag[a] = n[a][NB-1] ? -{n[a][NB-1], n[a]} : {n[a][NB-1], n[a]};
            dist_prod[a] = n[a] * c2[a];
            rad_prod[a]  = n_mag[a] * e2[a];
            plane_dist = plane_dist
                       + {{(SUM_W-PROD_W){dist_prod[a][PROD_W-1]}}, dist_prod[a]};
            rad  = rad + {{(SUM_W-PROD_W){rad_prod[a][PROD_W-1]}}, rad_prod[a]};
        end
        outer = plane_dist + rad;
        inner = plane_dist - rad;
        flags.below_outer = outer[SUM_W-1];
        flags.below_inner = inner[SUM_W-1];
    end

endmodule

>>> hw/rtl/aabb_frustum_classify_top.sv
// ----------------------------------------------------------------------------
// aabb_frustum_classify_top
// Classifies an axis-aligned box as outside, inside or straddling a frustum.
// ----------------------------------------------------------------------------
// Takes one box per clock and returns one classification per clock while no
// result is held. Between input and result, the first register holds the
// doubled centre and extent of the box, the second holds the class and tag;
// the plane products, sums and sign tests for all planes sit between them.
// A held result stalls the result register; the input stalls once the first
// register is full behind it. Planes are
// written through the configuration channel (index 0 to 5, 64-bit word); it
// is always ready, and indexes above 5 are dropped. Only the first
// PLANE_COUNT planes are tested; slots without a register act as zero planes.
module aabb_frustum_classify_top #(
    parameter int PLANE_COUNT = aabb_fc_pkg::PLANE_COUNT_DEF,
    parameter int COORD_BITS  = aabb_fc_pkg::COORD_BITS_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,

    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [aabb_fc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [aabb_fc_pkg::PLANE_BITS-1:0]      cfg_data,

    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic signed [COORD_BITS-1:0]            s_box_min_x,
    input  logic signed [COORD_BITS-1:0]            s_box_min_y,
    input  logic signed [COORD_BITS-1:0]            s_box_min_z,
    input  logic signed [COORD_BITS-1:0]            s_box_max_x,
    input  logic signed [COORD_BITS-1:0]            s_box_max_y,
    input  logic signed [COORD_BITS-1:0]            s_box_max_z,
    input  logic [aabb_fc_pkg::TAG_BITS-1:0]        s_box_tag,

    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic [aabb_fc_pkg::CLASS_BITS-1:0]      m_cull_class,
    output logic [aabb_fc_pkg::TAG_BITS-1:0]        m_result_tag
);

    localparam int AX = aabb_fc_pkg::AXES;

    logic [aabb_fc_pkg::PLANE_BITS-1:0] plane_reg [aabb_fc_pkg::REG_COUNT];

    logic signed [COORD_BITS-1:0] box_lo [AX];
    logic signed [COORD_BITS-1:0] box_hi [AX];
    logic signed [COORD_BITS:0]   c2_next [AX];
    logic signed [COORD_BITS:0]   e2_next [AX];

    logic                               a_valid_reg;
    logic signed [COORD_BITS:0]         a_c2_reg [AX];
    logic signed [COORD_BITS:0]         a_e2_reg [AX];
    logic [aabb_fc_pkg::TAG_BITS-1:0]   a_tag_reg;
    logic                               a_advance;
    logic                               s_take;

    aabb_fc_pkg::plane_flags_t          flags [PLANE_COUNT];
    logic                               any_out;
    logic                               any_not_in;
    aabb_fc_pkg::cull_class_t           class_next;

    logic                               m_valid_reg;
    aabb_fc_pkg::cull_class_t           m_class_reg;
    logic [aabb_fc_pkg::TAG_BITS-1:0]   m_tag_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < aabb_fc_pkg::REG_COUNT; i++) begin
                plane_reg[i] <= '0;
            end
        end else if (cfg_valid) begin
            for (int i = 0; i < aabb_fc_pkg::REG_COUNT; i++) begin
                if (cfg_index == aabb_fc_pkg::CFG_INDEX_BITS'(i)) begin
                    plane_reg[i] <= cfg_data;
                end
            end
        end
    end

    // handshake
    assign a_advance = a_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !a_valid_reg || a_advance;
    assign s_take    = s_valid && s_ready;

    always_comb begin
        box_lo[0] = s_box_min_x;
        box_lo[1] = s_box_min_y;
        box_lo[2] = s_box_min_z;
        box_hi[0] = s_box_max_x;
        box_hi[1] = s_box_max_y;
        box_hi[2] = s_box_max_z;
        for (int a = 0; a < AX; a++) begin
            c2_next[a] = {box_hi[a][COORD_BITS-1], box_hi[a]}
                       + {box_lo[a][COORD_BITS-1], box_lo[a]};
            e2_next[a] = {box_hi[a][COORD_BITS-1], box_hi[a]}
                       - {box_lo[a][COORD_BITS-1], box_lo[a]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (s_ready) begin
            a_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            a_c2_reg  <= c2_next;
            a_e2_reg  <= e2_next;
            a_tag_reg <= s_box_tag;
        end
    end

    for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
        if (p < aabb_fc_pkg::REG_COUNT) begin : g_reg
            aabb_fc_plane_test #(
                .COORD_BITS (COORD_BITS)
            ) u_test (
                .plane_word (plane_reg[p]),
                .c2         (a_c2_reg),
                .e2         (a_e2_reg),
                .flags      (flags[p])
            );
        end else begin : g_zero
            assign flags[p] = '0;
        end
    end

    always_comb begin
        any_out    = 1'b0;
        any_not_in = 1'b0;
        for (int p = 0; p < PLANE_COUNT; p++) begin
            any_out    = any_out | flags[p].below_outer;
            any_not_in = any_not_in | flags[p].below_inner;
        end
        if (any_out) begin
            class_next = aabb_fc_pkg::CLASS_OUTSIDE;
        end else if (!any_not_in) begin
            class_next = aabb_fc_pkg::CLASS_INSIDE;
        end else begin
            class_next = aabb_fc_pkg::CLASS_STRADDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            m_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_advance) begin
            m_class_reg <= class_next;
            m_tag_reg   <= a_tag_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_cull_class = m_class_reg;
    assign m_result_tag = m_tag_reg;

endmodule

>>> hw/rtl/aabb_fc_checker.sv
// ----------------------------------------------------------------------------
// aabb_fc_checker
// Port-level checks for aabb_frustum_classify_top, attached by bind.
// ----------------------------------------------------------------------------
`include "aabb_frustum_classify_top_assert.svh"

module aabb_fc_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 cfg_valid,
    input logic                                 cfg_ready,
    input logic                                 s_ready,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input logic [aabb_fc_pkg::CLASS_BITS-1:0]   m_cull_class,
    input logic [aabb_fc_pkg::TAG_BITS-1:0]     m_result_tag
);

    `AFC_ASSERT_NXT(a_stall_hold, m_valid && !m_ready, m_valid && $stable(m_cull_class) && $stable(m_result_tag), "result changed while stalled")

    `AFC_ASSERT_IMP(a_backup_only_full, !s_ready, m_valid && !m_ready, "input stalled with result side free")

    `AFC_ASSERT_IMP(a_class_code, m_valid, m_cull_class == aabb_fc_pkg::CLASS_OUTSIDE || m_cull_class == aabb_fc_pkg::CLASS_INSIDE || m_cull_class == aabb_fc_pkg::CLASS_STRADDLE, "undefined class code")

    `AFC_ASSERT_IMP(a_cfg_open, cfg_valid, cfg_ready, "configuration transaction refused")

endmodule

bind aabb_frustum_classify_top aabb_fc_checker u_aabb_fc_checker (.*);
